>>> rtl/core/signed_int_to_decimal_ascii_core_assert.svh
// Assertion macros used by the checker file.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define SI2DA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SI2DA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/si2da_pkg.sv
package si2da_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 6;
    localparam int unsigned EXP_W   = 4;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned STEP_W  = VALUE_W + 3;

    localparam logic [EXP_W-1:0]  TOP_EXP     = 4'd9;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    typedef struct packed {
        logic load;
        logic sign;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic done;
    } status_t;

    function automatic logic [VALUE_W-1:0] pow10(input logic [EXP_W-1:0] e);
        logic [VALUE_W-1:0] p;
        begin
            case (e)
                4'd0:    p = 32'd1;
                4'd1:    p = 32'd10;
                4'd2:    p = 32'd100;
                4'd3:    p = 32'd1000;
                4'd4:    p = 32'd10000;
                4'd5:    p = 32'd100000;
                4'd6:    p = 32'd1000000;
                4'd7:    p = 32'd10000000;
                4'd8:    p = 32'd100000000;
                4'd9:    p = 32'd1000000000;
                default: p = 32'd1;
            endcase
            return p;
        end
    endfunction

    // 10^e scaled by 2^k, for the binary search on one decimal digit
    function automatic logic [STEP_W-1:0] step_const(input logic [EXP_W-1:0] e,
                                                     input logic [1:0] k);
        logic [STEP_W-1:0] c;
        begin
            c = {3'b000, pow10(e)} << k;
            return c;
        end
    endfunction

endpackage

>>> rtl/core/si2da_datapath.sv
module si2da_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [si2da_pkg::VALUE_W-1:0]       value,
    input  si2da_pkg::cmd_t                     cmd,
    output si2da_pkg::status_t                  status,
    output logic [si2da_pkg::CHAR_W-1:0]        character,
    output logic                                last,
    output logic                                strobe
);

    logic [si2da_pkg::VALUE_W-1:0] mag_reg, mag_next;
    logic [si2da_pkg::EXP_W-1:0]   exp_reg, exp_next;
    logic [1:0]                    bit_reg, bit_next;
    logic [si2da_pkg::DIGIT_W-1:0] digit_reg, digit_next;
    logic                          started_reg, started_next;
    logic [si2da_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                          last_reg, last_next;
    logic                          strobe_reg, strobe_next;

    logic [si2da_pkg::STEP_W:0]    diff;
    logic                          ge;
    logic [si2da_pkg::DIGIT_W-1:0] digit_final;
    logic                          emit;

    assign diff = {4'b0000, mag_reg} -
                  {1'b0, si2da_pkg::step_const(exp_reg, bit_reg)};
    assign ge   = ~diff[si2da_pkg::STEP_W];
    assign digit_final = {digit_reg[3:1], ge};
    // leading zeros dropped; the units digit always goes out
    assign emit = (bit_reg == 2'd0) &&
                  ((digit_final != '0) || started_reg || (exp_reg == '0));

    assign status.neg  = value[si2da_pkg::VALUE_W-1];
    assign status.done = (exp_reg == '0) && (bit_reg == 2'd0);

    always_comb
    begin
        mag_next     = mag_reg;
        exp_next     = exp_reg;
        bit_next     = bit_reg;
        digit_next   = digit_reg;
        started_next = started_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        strobe_next  = 1'b0;
        if (cmd.load)
        begin
            // two's complement negate; the most negative value maps onto itself
            mag_next     = value[si2da_pkg::VALUE_W-1] ? (~value + 32'd1) : value;
            exp_next     = si2da_pkg::TOP_EXP;
            bit_next     = 2'd3;
            digit_next   = '0;
            started_next = 1'b0;
        end
        else if (cmd.sign)
        begin
            char_next   = si2da_pkg::ASCII_MINUS;
            last_next   = 1'b0;
            strobe_next = 1'b1;
        end
        else if (cmd.step)
        begin
            if (ge)
            begin
                mag_next = diff[si2da_pkg::VALUE_W-1:0];
            end
            if (bit_reg == 2'd3)
            begin
                digit_next = {ge, 3'b000};
            end
            else
            begin
                digit_next = digit_reg | ({3'b000, ge} << bit_reg);
            end
            bit_next = bit_reg - 2'd1;
            if (bit_reg == 2'd0)
            begin
                exp_next = exp_reg - 4'd1;
            end
            if (emit)
            begin
                char_next    = si2da_pkg::ASCII_ZERO + {2'b00, digit_final};
                last_next    = (exp_reg == '0);
                strobe_next  = 1'b1;
                started_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        exp_reg     <= exp_next;
        bit_reg     <= bit_next;
        digit_reg   <= digit_next;
        started_reg <= started_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign character = char_reg;
    assign last      = last_reg;
    assign strobe    = strobe_reg;

endmodule

>>> rtl/core/si2da_ctrl.sv
module si2da_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  si2da_pkg::status_t status,
    output si2da_pkg::cmd_t    cmd,
    output logic               busy
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SIGN = 3'b010,
        ST_CONV = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.sign   = 1'b0;
        cmd.step   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.neg ? ST_SIGN : ST_CONV;
                end
            end
            ST_SIGN:
            begin
                cmd.sign   = 1'b1;
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
                if (status.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> rtl/core/signed_int_to_decimal_ascii_core.sv
// Signed 32-bit integer to decimal ASCII text.
// Input: a transfer happens on a rising edge with start high and busy low;
// value is sampled at that edge. Output: one character per strobe pulse,
// character holds '-' or '0'..'9', last marks the final character of the
// value. Zero gives "0"; leading zeros are dropped.
// Each decimal digit is found by a 4-step binary search against 8, 4, 2
// and 1 times its power of ten, one 35-bit subtract-compare per cycle,
// over the ten digit places from 10^9 down to 10^0. A negative value
// first gives the '-'. No new value is accepted while busy, that is
// until the last character has been found. The first character is the
// '-' when negative, else the first digit that is not a leading zero.
// Characters go out as they are found.
// The receiver cannot stall: every strobe pulse is a transfer.
// Reset (rst_n low) aborts any conversion, clears strobe and returns to idle.
module signed_int_to_decimal_ascii_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [si2da_pkg::VALUE_W-1:0]      value,
    output logic                               strobe,
    output logic [si2da_pkg::CHAR_W-1:0]       character,
    output logic                               last
);

    si2da_pkg::cmd_t    cmd;
    si2da_pkg::status_t status;

    si2da_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    si2da_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .character (character),
        .last      (last),
        .strobe    (strobe)
    );

endmodule

>>> rtl/core/si2da_checker.sv
`include "signed_int_to_decimal_ascii_core_assert.svh"

module si2da_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          strobe,
    input logic [si2da_pkg::CHAR_W-1:0]  character,
    input logic                          last
);

    logic is_minus;
    logic is_digit;

    assign is_minus = (character == si2da_pkg::ASCII_MINUS);
    assign is_digit = (character >= si2da_pkg::ASCII_ZERO) &&
                      (character <= si2da_pkg::ASCII_ZERO + 6'd9);

    // only '-' or a decimal digit ever goes out
    `SI2DA_ASSERT(a_char_range, clk, rst_n, strobe |-> (is_minus || is_digit), "character out of range")

    // the sign never ends a run
    `SI2DA_ASSERT(a_minus_not_last, clk, rst_n, (strobe && is_minus) |-> !last, "minus marked last")

    // more characters pending keeps the block busy
    `SI2DA_ASSERT(a_busy_mid_run, clk, rst_n, (strobe && !last) |-> busy, "idle in the middle of a run")

    // an accepted value starts work
    `SI2DA_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "transfer did not start work")

    // reset silences the strobe output
    `SI2DA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !strobe, "strobe during reset")

endmodule

bind signed_int_to_decimal_ascii_core si2da_checker u_si2da_checker (.*);
